@@ hw/rtl/inertial_baro_height_estimator_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the inertial and barometric height estimator
// Shared property forms used by the modules that carry assertions.
// ----------------------------------------------------------------------------
`ifndef INERTIAL_BARO_HEIGHT_ESTIMATOR_TOP_ASSERT_SVH
`define INERTIAL_BARO_HEIGHT_ESTIMATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, disabled during reset.
`define IBHE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, disabled during reset.
`define IBHE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ibhe_pkg.sv @@
// ----------------------------------------------------------------------------
// ibhe_pkg
// Types, constants and helpers shared by the height estimator modules.
// ----------------------------------------------------------------------------
package ibhe_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int AXES          = 3;
    localparam int GRAV_RATE     = 164;
    localparam int CAL_ERR_LIMIT = 5;

    localparam int WIDE_W = 84;
    localparam int OPA_W  = 58;
    localparam int HALF_W = 29;
    localparam int MUL_W  = 55;
    localparam int GRAV_W = 40;
    localparam int FILT_W = 40;
    localparam int POS_W  = 56;
    localparam int VEL_W  = 48;
    localparam int AD_W   = 40;
    localparam int T1_W   = 48;
    localparam int ED_W   = 58;
    localparam int EW_W   = 56;

    localparam logic [23:0] RST_STEP_TIME        = 24'd33554;
    localparam logic [15:0] RST_BARO_WEIGHT      = 16'd4096;
    localparam logic [23:0] RST_GRAVITY_START    = 24'd251058;
    localparam logic [15:0] RST_DEAD_BAND        = 16'd1024;
    localparam logic [15:0] RST_FILTER_GAIN      = 16'd19661;
    localparam logic [23:0] RST_VELOCITY_LIMIT   = 24'd38400;
    localparam logic [15:0] RST_PUBLISH_INTERVAL = 16'd10;
    localparam logic [15:0] RST_CAL_HOLD         = 16'd250;

    typedef enum logic [2:0] {
        CFG_STEP_TIME        = 3'd0,
        CFG_BARO_WEIGHT      = 3'd1,
        CFG_GRAVITY_START    = 3'd2,
        CFG_DEAD_BAND        = 3'd3,
        CFG_FILTER_GAIN      = 3'd4,
        CFG_VELOCITY_LIMIT   = 3'd5,
        CFG_PUBLISH_INTERVAL = 3'd6,
        CFG_CAL_HOLD         = 3'd7
    } t_cfg_idx;

    typedef enum logic [0:0] {
        CS_IDLE,
        CS_RUN
    } t_state;

    typedef enum logic [3:0] {
        ST_GRAV,
        ST_FILT0,
        ST_FILT1,
        ST_FILT2,
        ST_AD,
        ST_PV,
        ST_PA,
        ST_ED,
        ST_EW,
        ST_EV,
        ST_PUB
    } t_step;

    typedef enum logic [2:0] {
        PH_OP,
        PH_LO,
        PH_HI,
        PH_RND,
        PH_WB
    } t_phase;

    typedef struct packed {
        logic   capture;
        t_step  step;
        t_phase phase;
        logic   commit;
    } t_cmd;

    typedef struct packed {
        logic grav_en;
    } t_stat;

    function automatic logic signed [WIDE_W-1:0] sat_w(
        input logic signed [WIDE_W-1:0] v,
        input int unsigned              w
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = $signed((WIDE_W'(1) << (w - 1)) - WIDE_W'(1));
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/ibhe_ctrl.sv @@
// ----------------------------------------------------------------------------
// ibhe_ctrl
// Sequencer that walks the datapath through the steps and phases of one update.
// ----------------------------------------------------------------------------
`include "inertial_baro_height_estimator_top_assert.svh"

module ibhe_ctrl
    import ibhe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    t_step  r_step, n_step;
    t_phase r_phase, n_phase;
    logic   r_out_valid, n_out_valid;
    logic   commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CS_IDLE;
            r_step      <= ST_GRAV;
            r_phase     <= PH_OP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_phase     = r_phase;
        n_out_valid = r_out_valid & ~i_out_ready;
        case (r_state)
            CS_IDLE: begin
                if (i_in_valid) begin
                    n_state = CS_RUN;
                    n_step  = ST_GRAV;
                    n_phase = PH_OP;
                end
            end
            CS_RUN: begin
                if (r_step == ST_PUB) begin
                    if (commit) begin
                        n_state     = CS_IDLE;
                        n_out_valid = 1'b1;
                    end
                end else if (r_step == ST_GRAV && r_phase == PH_OP && !i_stat.grav_en) begin
                    n_step = ST_FILT0;
                end else if (r_phase == PH_WB) begin
                    n_phase = PH_OP;
                    n_step  = t_step'(r_step + 4'd1);
                end else begin
                    n_phase = t_phase'(r_phase + 3'd1);
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    always_comb begin
        commit        = (r_state == CS_RUN) && (r_step == ST_PUB) &&
                        (!r_out_valid || i_out_ready);
        o_in_ready    = (r_state == CS_IDLE);
        o_out_valid   = r_out_valid;
        o_cmd.capture = (r_state == CS_IDLE) && i_in_valid;
        o_cmd.step    = r_step;
        o_cmd.phase   = r_phase;
        o_cmd.commit  = commit;
    end

    `IBHE_ASSERT_NEXT(a_accept_starts, i_in_valid && o_in_ready, r_state == CS_RUN && r_step == ST_GRAV && r_phase == PH_OP, "Accepted beat did not start the update sequence.")
    `IBHE_ASSERT_NEXT(a_commit_shows, o_cmd.commit, r_out_valid && r_state == CS_IDLE, "Committed result is not presented.")
    `IBHE_ASSERT_IMP(a_commit_free, o_cmd.commit, !r_out_valid || i_out_ready, "Result committed over an untaken beat.")
    `IBHE_ASSERT_IMP(a_pub_no_phase, r_state == CS_RUN && r_step == ST_PUB, r_phase == PH_OP, "Publish step entered with a multiply phase pending.")

endmodule

@@ hw/rtl/ibhe_datapath.sv @@
// ----------------------------------------------------------------------------
// ibhe_datapath
// Configuration, estimator state and one shared multiplier with rounding.
// ----------------------------------------------------------------------------
module ibhe_datapath
    import ibhe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic signed [23:0] i_acc_north,
    input  logic signed [23:0] i_acc_east,
    input  logic signed [23:0] i_acc_up,
    input  logic signed [31:0] i_height,
    input  logic               i_height_stable,
    input  logic               i_small_angle,
    input  logic [31:0]        i_now_ms,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic signed [23:0] o_filt_north,
    output logic signed [23:0] o_filt_east,
    output logic signed [23:0] o_filt_up,
    output logic signed [31:0] o_pos_up,
    output logic signed [24:0] o_vel_up,
    output logic               o_published,
    output logic               o_cal_done
);

    localparam int SH = FRAC_BITS - 8;
    localparam logic signed [WIDE_W-1:0] HALF_SH =
        (SH > 0) ? $signed(WIDE_W'(1) << (SH - 1)) : '0;
    localparam logic signed [WIDE_W-1:0] CAL_LIM =
        $signed(WIDE_W'(CAL_ERR_LIMIT) << FRAC_BITS);

    function automatic logic signed [WIDE_W-1:0] to_int(input logic signed [31:0] p);
        logic signed [WIDE_W-1:0] e;
        e = $signed(WIDE_W'(p));
        return e <<< SH;
    endfunction

    function automatic logic signed [WIDE_W-1:0] to_port(input logic signed [WIDE_W-1:0] v);
        return (v + HALF_SH) >>> SH;
    endfunction

    logic [23:0] r_step_time, r_velocity_limit;
    logic [15:0] r_baro_weight, r_dead_band, r_filter_gain, r_publish_interval, r_cal_hold;

    logic signed [GRAV_W-1:0] r_grav;
    logic                     r_cal;
    logic [31:0]              r_cal_mark;
    logic signed [FILT_W-1:0] r_filt [AXES];
    logic signed [POS_W-1:0]  r_pos;
    logic signed [VEL_W-1:0]  r_vel;
    logic [31:0]              r_pub_mark;
    logic signed [31:0]       r_held_pos;
    logic signed [24:0]       r_held_vel;
    logic signed [23:0]       r_o_filt [AXES];
    logic                     r_o_pub;
    logic                     r_o_cal;

    logic signed [23:0]       r_acc [AXES];
    logic signed [31:0]       r_h;
    logic                     r_small;
    logic [31:0]              r_now;
    logic signed [OPA_W-1:0]  r_opa;
    logic [23:0]              r_m;
    logic signed [MUL_W-1:0]  r_plo, r_phi;
    logic signed [WIDE_W-1:0] r_prod;
    logic signed [AD_W-1:0]   r_ad;
    logic signed [T1_W-1:0]   r_t1;
    logic signed [ED_W-1:0]   r_ed;
    logic signed [EW_W-1:0]   r_ew;

    logic signed [WIDE_W-1:0] grav_err, db, ax, dz, opa_n;
    logic [23:0]              m_n;
    logic [1:0]               axis;
    logic signed [29:0]       mul_a;
    logic signed [24:0]       mul_b;
    logic signed [MUL_W-1:0]  mul_p;
    logic signed [WIDE_W-1:0] full, rnd;
    logic signed [WIDE_W-1:0] grav_sum, filt_sum, pa_pos, pa_vel, ew_sat, ew_pos, ev_vel;
    logic signed [WIDE_W-1:0] pub_pos, pub_vel, lim;
    logic                     err_small, pub_due;
    logic signed [WIDE_W-1:0] grav_load, grav_rst;

    assign o_cfg_ready = 1'b1;
    assign o_stat.grav_en = !r_cal && r_small;

    always_comb begin
        grav_err = to_int(32'(r_acc[2])) - WIDE_W'(r_grav);
        err_small = (grav_err < CAL_LIM) && (grav_err > -CAL_LIM);
        db = $signed(WIDE_W'(r_dead_band) << SH);
        case (i_cmd.step)
            ST_FILT1: axis = 2'd1;
            ST_FILT2: axis = 2'd2;
            default:  axis = 2'd0;
        endcase
        ax = to_int(32'(r_acc[axis]));
        if (axis == 2'd2) begin
            ax = ax - WIDE_W'(r_grav);
        end
        if (ax > db) begin
            dz = ax - db;
        end else if (ax < -db) begin
            dz = ax + db;
        end else begin
            dz = '0;
        end
        case (i_cmd.step)
            ST_GRAV: begin
                opa_n = grav_err;
                m_n   = 24'(GRAV_RATE);
            end
            ST_FILT0, ST_FILT1, ST_FILT2: begin
                opa_n = dz - WIDE_W'(r_filt[axis]);
                m_n   = {8'd0, r_filter_gain};
            end
            ST_AD: begin
                opa_n = WIDE_W'(r_filt[2]);
                m_n   = r_step_time;
            end
            ST_PV: begin
                opa_n = WIDE_W'(r_vel);
                m_n   = r_step_time;
            end
            ST_PA: begin
                opa_n = WIDE_W'(r_ad);
                m_n   = r_step_time;
            end
            ST_ED: begin
                opa_n = to_int(r_h) - WIDE_W'(r_pos);
                m_n   = r_step_time;
            end
            ST_EW: begin
                opa_n = WIDE_W'(r_ed);
                m_n   = {8'd0, r_baro_weight};
            end
            ST_EV: begin
                opa_n = WIDE_W'(r_ew);
                m_n   = {8'd0, r_baro_weight};
            end
            default: begin
                opa_n = '0;
                m_n   = '0;
            end
        endcase
    end

    always_comb begin
        if (i_cmd.phase == PH_LO) begin
            mul_a = $signed({1'b0, r_opa[HALF_W-1:0]});
        end else begin
            mul_a = $signed({r_opa[OPA_W-1], r_opa[OPA_W-1:HALF_W]});
        end
        mul_b = $signed({1'b0, r_m});
        mul_p = mul_a * mul_b;
        full  = (WIDE_W'(r_phi) <<< HALF_W) + WIDE_W'(r_plo);
        case (i_cmd.step)
            ST_GRAV, ST_FILT0, ST_FILT1, ST_FILT2: rnd = (full + (WIDE_W'(1) <<< 15)) >>> 16;
            ST_EW, ST_EV:                          rnd = (full + (WIDE_W'(1) <<< 11)) >>> 12;
            default:                               rnd = (full + (WIDE_W'(1) <<< 23)) >>> 24;
        endcase
    end

    always_comb begin
        grav_sum = sat_w(WIDE_W'(r_grav) + r_prod, GRAV_W);
        filt_sum = sat_w(WIDE_W'(r_filt[axis]) + r_prod, FILT_W);
        pa_pos   = sat_w(WIDE_W'(r_pos) + WIDE_W'(r_t1) + ((r_prod + 1) >>> 1), POS_W);
        pa_vel   = sat_w(WIDE_W'(r_vel) + WIDE_W'(r_ad), VEL_W);
        ew_sat   = sat_w(r_prod, EW_W);
        ew_pos   = sat_w(WIDE_W'(r_pos) + ew_sat, POS_W);
        ev_vel   = sat_w(WIDE_W'(r_vel) + r_prod, VEL_W);
        pub_due  = (r_now - r_pub_mark) >= {16'd0, r_publish_interval};
        pub_pos  = sat_w(to_port(WIDE_W'(r_pos)), 32);
        lim      = $signed(WIDE_W'(r_velocity_limit));
        pub_vel  = to_port(WIDE_W'(r_vel));
        if (pub_vel > lim) begin
            pub_vel = lim;
        end
        if (pub_vel < -lim) begin
            pub_vel = -lim;
        end
        pub_vel   = sat_w(pub_vel, 25);
        grav_load = sat_w(to_int($signed({8'd0, i_cfg_data})), GRAV_W);
        grav_rst  = sat_w(to_int($signed({8'd0, RST_GRAVITY_START})), GRAV_W);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_acc[0] <= i_acc_north;
            r_acc[1] <= i_acc_east;
            r_acc[2] <= i_acc_up;
            r_h      <= i_height_stable ? i_height : 32'sd0;
            r_small  <= i_small_angle;
            r_now    <= i_now_ms;
        end
        case (i_cmd.phase)
            PH_OP: begin
                r_opa <= opa_n[OPA_W-1:0];
                r_m   <= m_n;
            end
            PH_LO:  r_plo  <= mul_p;
            PH_HI:  r_phi  <= mul_p;
            PH_RND: r_prod <= rnd;
            PH_WB: begin
                case (i_cmd.step)
                    ST_AD:   r_ad <= r_prod[AD_W-1:0];
                    ST_PV:   r_t1 <= r_prod[T1_W-1:0];
                    ST_ED:   r_ed <= r_prod[ED_W-1:0];
                    ST_EW:   r_ew <= ew_sat[EW_W-1:0];
                    default: r_ad <= r_ad;
                endcase
            end
            default: r_m <= r_m;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time        <= RST_STEP_TIME;
            r_baro_weight      <= RST_BARO_WEIGHT;
            r_dead_band        <= RST_DEAD_BAND;
            r_filter_gain      <= RST_FILTER_GAIN;
            r_velocity_limit   <= RST_VELOCITY_LIMIT;
            r_publish_interval <= RST_PUBLISH_INTERVAL;
            r_cal_hold         <= RST_CAL_HOLD;
            r_grav             <= grav_rst[GRAV_W-1:0];
            r_cal              <= 1'b0;
            r_cal_mark         <= '0;
            for (int i = 0; i < AXES; i++) begin
                r_filt[i]   <= '0;
                r_o_filt[i] <= '0;
            end
            r_pos      <= '0;
            r_vel      <= '0;
            r_pub_mark <= '0;
            r_held_pos <= '0;
            r_held_vel <= '0;
            r_o_pub    <= 1'b0;
            r_o_cal    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_STEP_TIME:        r_step_time        <= i_cfg_data;
                    CFG_BARO_WEIGHT:      r_baro_weight      <= i_cfg_data[15:0];
                    CFG_GRAVITY_START:    r_grav             <= grav_load[GRAV_W-1:0];
                    CFG_DEAD_BAND:        r_dead_band        <= i_cfg_data[15:0];
                    CFG_FILTER_GAIN:      r_filter_gain      <= i_cfg_data[15:0];
                    CFG_VELOCITY_LIMIT:   r_velocity_limit   <= i_cfg_data;
                    CFG_PUBLISH_INTERVAL: r_publish_interval <= i_cfg_data[15:0];
                    CFG_CAL_HOLD:         r_cal_hold         <= i_cfg_data[15:0];
                    default:              r_step_time        <= r_step_time;
                endcase
            end
            if (i_cmd.phase == PH_WB) begin
                case (i_cmd.step)
                    ST_GRAV: begin
                        r_grav <= grav_sum[GRAV_W-1:0];
                        if (err_small) begin
                            if ((r_now - r_cal_mark) > {16'd0, r_cal_hold}) begin
                                r_cal <= 1'b1;
                            end
                        end else begin
                            r_cal      <= 1'b0;
                            r_cal_mark <= r_now;
                        end
                    end
                    ST_FILT0, ST_FILT1, ST_FILT2: begin
                        r_filt[axis] <= r_cal ? filt_sum[FILT_W-1:0] : '0;
                    end
                    ST_PA: begin
                        r_pos <= pa_pos[POS_W-1:0];
                        r_vel <= pa_vel[VEL_W-1:0];
                    end
                    ST_EW:   r_pos <= ew_pos[POS_W-1:0];
                    ST_EV:   r_vel <= ev_vel[VEL_W-1:0];
                    default: r_cal <= r_cal;
                endcase
            end
            if (i_cmd.commit) begin
                if (pub_due) begin
                    r_held_pos <= pub_pos[31:0];
                    r_held_vel <= pub_vel[24:0];
                    r_pub_mark <= r_now;
                end
                r_o_pub <= pub_due;
                r_o_cal <= r_cal;
                for (int i = 0; i < AXES; i++) begin
                    r_o_filt[i] <= 24'(sat_w(to_port(WIDE_W'(r_filt[i])), 24));
                end
            end
        end
    end

    assign o_filt_north = r_o_filt[0];
    assign o_filt_east  = r_o_filt[1];
    assign o_filt_up    = r_o_filt[2];
    assign o_pos_up     = r_held_pos;
    assign o_vel_up     = r_held_vel;
    assign o_published  = r_o_pub;
    assign o_cal_done   = r_o_cal;

endmodule

@@ hw/rtl/inertial_baro_height_estimator_top.sv @@
// ----------------------------------------------------------------------------
// inertial_baro_height_estimator_top
// Vertical height estimator fusing earth-frame acceleration and barometer.
//
//   Channel  Valid        Ready        Payload
//   in       i_in_valid   o_in_ready   i_acc_*, i_height*, i_small_angle, i_now_ms
//   out      o_out_valid  i_out_ready  o_filt_*, o_pos_up, o_vel_up, o_published,
//                                      o_cal_done
//   cfg      i_cfg_valid  o_cfg_ready  i_cfg_index, i_cfg_data
//
// An update walks ten multiply steps that share one 30x25 multiplier, each through
// operand, low, high, round and write-back phases; the gravity step is skipped
// once calibration is done or while the small-angle flag is clear. A new beat is
// accepted in the cycle after the previous result is committed to the output
// register; a stalled output holds the sequencer in its publish step.
// Reset is synchronous and active low; configuration writes complete at once.
// ----------------------------------------------------------------------------
module inertial_baro_height_estimator_top
    import ibhe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [23:0] i_acc_north,
    input  logic signed [23:0] i_acc_east,
    input  logic signed [23:0] i_acc_up,
    input  logic signed [31:0] i_height,
    input  logic               i_height_stable,
    input  logic               i_small_angle,
    input  logic [31:0]        i_now_ms,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_filt_north,
    output logic signed [23:0] o_filt_east,
    output logic signed [23:0] o_filt_up,
    output logic signed [31:0] o_pos_up,
    output logic signed [24:0] o_vel_up,
    output logic               o_published,
    output logic               o_cal_done
);

    t_cmd  cmd;
    t_stat stat;

    ibhe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ibhe_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_acc_north     (i_acc_north),
        .i_acc_east      (i_acc_east),
        .i_acc_up        (i_acc_up),
        .i_height        (i_height),
        .i_height_stable (i_height_stable),
        .i_small_angle   (i_small_angle),
        .i_now_ms        (i_now_ms),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_filt_north    (o_filt_north),
        .o_filt_east     (o_filt_east),
        .o_filt_up       (o_filt_up),
        .o_pos_up        (o_pos_up),
        .o_vel_up        (o_vel_up),
        .o_published     (o_published),
        .o_cal_done      (o_cal_done)
    );

endmodule
